// ----- rtl/tpsc_pkg.sv -----
// shared types and constants for the three-point stick calibration pipeline
// no dependencies; imported by every module of the block
package tpsc_pkg;

    localparam int DATA_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int FULL_SPAN_DEF = 2048;
    localparam int OUT_MIN_DEF   = -1024;
    localparam int OUT_MAX_DEF   = 1024;
    localparam int SAT_MAX       = 32767;
    localparam int SAT_MIN       = -32768;
    // scaled numerator width at the default span
    localparam int NUM_W_DEF     = DATA_W + $clog2(FULL_SPAN_DEF / 2 + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH   = 2'd2;

    typedef logic signed [DATA_W-1:0] t_sample;

    // offset added after the divide
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_MIN,
        BASE_MAX
    } t_base;

    // per-beat side information carried alongside the divider
    typedef struct packed {
        logic    neg;
        logic    degen;
        t_base   base;
        t_sample raw;
    } t_side;

endpackage

// ----- rtl/tpsc_map.sv -----
// front end: segment select, clamp and offset, then magnitude and scale
// depends on tpsc_pkg; feeds tpsc_div
module tpsc_map #(
    parameter int FULL_SPAN = tpsc_pkg::FULL_SPAN_DEF,
    parameter int NUM_W     = tpsc_pkg::NUM_W_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  tpsc_pkg::t_sample         i_raw,
    input  tpsc_pkg::t_sample         i_cal_low,
    input  tpsc_pkg::t_sample         i_cal_center,
    input  tpsc_pkg::t_sample         i_cal_high,
    output logic                      o_valid,
    output logic [NUM_W-1:0]          o_num,
    output logic [tpsc_pkg::DATA_W-1:0] o_div,
    output tpsc_pkg::t_side           o_side
);
    import tpsc_pkg::*;

    localparam int HALF = FULL_SPAN / 2;

    logic signed [DATA_W:0] v, lo, ce, hi, lim, vc, n_d, n_w;
    logic                   asc, below, n_degen;
    t_base                  n_base;

    // stage 1 registers
    logic                   r_v1;
    logic signed [DATA_W:0] r_d, r_w;
    t_base                  r_base;
    logic                   r_degen;
    t_sample                r_raw;

    // stage 2 results
    logic [DATA_W-1:0]      d_mag, w_mag;
    logic [NUM_W-1:0]       n_num;
    logic                   r_v2;
    logic [NUM_W-1:0]       r_num;
    logic [DATA_W-1:0]      r_div;
    t_side                  r_side;

    always_comb begin
        v       = {i_raw[DATA_W-1], i_raw};
        lo      = {i_cal_low[DATA_W-1], i_cal_low};
        ce      = {i_cal_center[DATA_W-1], i_cal_center};
        hi      = {i_cal_high[DATA_W-1], i_cal_high};
        n_degen = (ce == lo) || (ce == hi);
        asc     = lo < hi;
        below   = v <= ce;
        // end of travel on this side of center
        lim     = (asc == below) ? lo : hi;
        if (below) begin
            vc = (v < lim) ? lim : v;
        end else begin
            vc = (v > lim) ? lim : v;
        end
        n_d    = vc - (below ? lim : ce);
        n_w    = (asc ^ below) ? (lim - ce) : (ce - lim);
        n_base = below ? (asc ? BASE_MIN : BASE_MAX) : BASE_ZERO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_d     <= n_d;
        r_w     <= n_w;
        r_base  <= n_base;
        r_degen <= n_degen;
        r_raw   <= i_raw;
    end

    // sign-magnitude so the divider truncates toward zero
    always_comb begin
        d_mag = r_d[DATA_W] ? DATA_W'(-r_d) : r_d[DATA_W-1:0];
        w_mag = r_w[DATA_W] ? DATA_W'(-r_w) : r_w[DATA_W-1:0];
        n_num = NUM_W'(d_mag) * NUM_W'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_num        <= n_num;
        r_div        <= w_mag;
        r_side.neg   <= r_d[DATA_W] ^ r_w[DATA_W];
        r_side.degen <= r_degen;
        r_side.base  <= r_base;
        r_side.raw   <= r_raw;
    end

    assign o_valid = r_v2;
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

// ----- rtl/tpsc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on tpsc_pkg; side information rides along with each beat
module tpsc_div #(
    parameter int NUM_W = tpsc_pkg::NUM_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [tpsc_pkg::DATA_W-1:0] i_div,
    input  tpsc_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [NUM_W-1:0]            o_quo,
    output tpsc_pkg::t_side             o_side
);
    import tpsc_pkg::*;

    logic [DATA_W-1:0] s_rem  [0:NUM_W];
    logic [NUM_W-1:0]  s_nq   [0:NUM_W];
    logic [DATA_W-1:0] s_dv   [0:NUM_W];
    logic              s_vld  [0:NUM_W];
    t_side             s_side [0:NUM_W];

    assign s_rem[0]  = '0;
    assign s_nq[0]   = i_num;
    assign s_dv[0]   = i_div;
    assign s_vld[0]  = i_valid;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DATA_W:0]   t;
        logic              ge;
        logic [DATA_W-1:0] n_rem;
        logic [DATA_W-1:0] r_rem;
        logic [NUM_W-1:0]  r_nq;
        logic [DATA_W-1:0] r_dv;
        logic              r_vld;
        t_side             r_side;

        always_comb begin
            t     = {s_rem[k], s_nq[k][NUM_W-1]};
            ge    = t >= {1'b0, s_dv[k]};
            n_rem = ge ? DATA_W'(t - {1'b0, s_dv[k]}) : t[DATA_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
            r_rem  <= n_rem;
            // numerator bits shift out as quotient bits shift in
            r_nq   <= {s_nq[k][NUM_W-2:0], ge};
            r_dv   <= s_dv[k];
            r_side <= s_side[k];
        end

        assign s_rem[k+1]  = r_rem;
        assign s_nq[k+1]   = r_nq;
        assign s_dv[k+1]   = r_dv;
        assign s_vld[k+1]  = r_vld;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_vld[NUM_W];
    assign o_quo   = s_nq[NUM_W];
    assign o_side  = s_side[NUM_W];

    // partial remainder never reaches the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_vld[NUM_W] && (s_dv[NUM_W] != '0) |-> s_rem[NUM_W] < s_dv[NUM_W])
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/tpsc_out.sv -----
// back end: apply sign and segment offset, saturate, register the result
// depends on tpsc_pkg; takes the quotient from tpsc_div
module tpsc_out #(
    parameter int NUM_W   = tpsc_pkg::NUM_W_DEF,
    parameter int OUT_MIN = tpsc_pkg::OUT_MIN_DEF,
    parameter int OUT_MAX = tpsc_pkg::OUT_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_quo,
    input  tpsc_pkg::t_side   i_side,
    output logic              o_valid,
    output tpsc_pkg::t_sample o_value,
    output logic              o_flag
);
    import tpsc_pkg::*;

    localparam int SUM_W = NUM_W + 2;
    localparam logic signed [SUM_W-1:0] B_MIN = SUM_W'(OUT_MIN);
    localparam logic signed [SUM_W-1:0] B_MAX = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(SAT_MAX);
    localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(SAT_MIN);

    logic signed [SUM_W-1:0] q_s, base_v, sum;
    t_sample                 n_value;
    logic                    r_valid;
    t_sample                 r_value;
    logic                    r_flag;

    always_comb begin
        q_s = $signed({2'b00, i_quo});
        if (i_side.neg) begin
            q_s = -q_s;
        end
        case (i_side.base)
            BASE_MIN: base_v = B_MIN;
            BASE_MAX: base_v = B_MAX;
            default:  base_v = '0;
        endcase
        sum = q_s + base_v;
        if (i_side.degen) begin
            n_value = i_side.raw;
        end else if (sum > S_MAX) begin
            n_value = t_sample'(SAT_MAX);
        end else if (sum < S_MIN) begin
            n_value = t_sample'(SAT_MIN);
        end else begin
            n_value = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_value <= n_value;
        r_flag  <= i_side.degen;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_flag  = r_flag;

endmodule

// ----- rtl/three_point_stick_calibration_top.sv -----
// top level of the three-point stick calibration: config registers and pipeline
// depends on tpsc_pkg, tpsc_map, tpsc_div, tpsc_out
//
// Maps a signed 16-bit raw reading through a low/center/high calibration into
// OUT_MIN..OUT_MAX, saturated to signed 16 bits.
// Input: a beat is taken at each clock edge with start high and busy low;
// busy stays low, so a new sample can enter every cycle.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 low, 1 center,
// 2 high); other indexes are ignored. Write only while no beat is in flight.
// Output: o_valid is high for exactly one cycle with o_calibrated_value and
// o_setup_invalid; there is no back-pressure, the receiver must take it.
// Pipeline: tpsc_map, tpsc_div, tpsc_out; the divider resolves one quotient bit
// a stage, with NUM_W = 16 + clog2(FULL_SPAN/2 + 1) (27 at the default span).
// Throughput: one beat per cycle.
// Reset: synchronous active low; clears the pipeline valids and sets all three
// calibration registers to 0, which reads as a degenerate setup (pass-through).
module three_point_stick_calibration_top #(
    parameter int FULL_SPAN = tpsc_pkg::FULL_SPAN_DEF,
    parameter int OUT_MIN   = tpsc_pkg::OUT_MIN_DEF,
    parameter int OUT_MAX   = tpsc_pkg::OUT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tpsc_pkg::t_sample              i_raw_sample,
    input  logic                           i_cfg_we,
    input  logic [tpsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  tpsc_pkg::t_sample              i_cfg_data,
    output logic                           o_valid,
    output tpsc_pkg::t_sample              o_calibrated_value,
    output logic                           o_setup_invalid
);
    import tpsc_pkg::*;

    localparam int HALF   = FULL_SPAN / 2;
    localparam int NUM_W  = DATA_W + $clog2(HALF + 1);
    localparam int LAT    = NUM_W + 3;

    t_sample r_cal_low, r_cal_center, r_cal_high;

    logic              accept;
    logic              m_valid, d_valid;
    logic [NUM_W-1:0]  m_num, d_quo;
    logic [DATA_W-1:0] m_div;
    t_side             m_side, d_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low    <= '0;
            r_cal_center <= '0;
            r_cal_high   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAL_LOW:    r_cal_low    <= i_cfg_data;
                CFG_CAL_CENTER: r_cal_center <= i_cfg_data;
                CFG_CAL_HIGH:   r_cal_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpsc_map #(
        .FULL_SPAN (FULL_SPAN),
        .NUM_W     (NUM_W)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_raw        (i_raw_sample),
        .i_cal_low    (r_cal_low),
        .i_cal_center (r_cal_center),
        .i_cal_high   (r_cal_high),
        .o_valid      (m_valid),
        .o_num        (m_num),
        .o_div        (m_div),
        .o_side       (m_side)
    );

    tpsc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .i_num   (m_num),
        .i_div   (m_div),
        .i_side  (m_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    tpsc_out #(
        .NUM_W   (NUM_W),
        .OUT_MIN (OUT_MIN),
        .OUT_MAX (OUT_MAX)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_side  (d_side),
        .o_valid (o_valid),
        .o_value (o_calibrated_value),
        .o_flag  (o_setup_invalid)
    );

    // every result beat traces back to an accepted sample
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LAT))
        else $error("result beat without an accepted sample");

    // an accepted sample always comes out after the fixed latency
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept, LAT) && $past(i_rst_n, LAT) |-> o_valid || !$past(i_rst_n, LAT - 1))
        else $error("accepted sample lost in the pipeline");

    // degenerate setup passes the raw sample through
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_setup_invalid |-> o_calibrated_value == $past(i_raw_sample, LAT))
        else $error("pass-through value differs from raw sample");

endmodule

// ----- sim/tb_top.sv -----
// testbench for three_point_stick_calibration_top: directed and random samples over many setups
// depends on rtl/tpsc_pkg.sv and the rtl of the block; results checked in order by a local mapper
`timescale 1ns / 1ps

module tb_top;
    import tpsc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_SETUPS = 14;
    localparam int SAMPLES_PER_SETUP = 86;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_sample value;
        logic    flag;
    } t_cal_out;

    // holds the calibration copy and the queue of calibrated values still owed
    class calib_tracker;
        t_sample  reg_low;
        t_sample  reg_center;
        t_sample  reg_high;
        t_cal_out owed[$];
        int       fail_count;

        function new();
            reg_low = '0;
            reg_center = '0;
            reg_high = '0;
            fail_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, t_sample data);
            case (idx)
                CFG_CAL_LOW: reg_low = data;
                CFG_CAL_CENTER: reg_center = data;
                CFG_CAL_HIGH: reg_high = data;
                default: ;
            endcase
        endfunction

        function t_cal_out map_sample(t_sample raw);
            t_cal_out res;
            longint   v;
            longint   lo;
            longint   ce;
            longint   hi;
            longint   d;
            longint   w;
            longint   base;
            longint   r;
            v = raw;
            lo = reg_low;
            ce = reg_center;
            hi = reg_high;
            if (ce == lo || ce == hi) begin
                res.value = raw;
                res.flag = 1'b1;
                return res;
            end
            if (lo < hi) begin
                if (v <= ce) begin
                    if (v < lo) v = lo;
                    d = v - lo;
                    w = ce - lo;
                    base = OUT_MIN_DEF;
                end else begin
                    if (v > hi) v = hi;
                    d = v - ce;
                    w = hi - ce;
                    base = 0;
                end
            end else begin
                // inverted travel, also taken when low equals high
                if (v <= ce) begin
                    if (v < hi) v = hi;
                    d = v - hi;
                    w = hi - ce;
                    base = OUT_MAX_DEF;
                end else begin
                    if (v > lo) v = lo;
                    d = v - ce;
                    w = ce - lo;
                    base = 0;
                end
            end
            r = (d * (FULL_SPAN_DEF / 2)) / w + base;
            if (r > SAT_MAX) r = SAT_MAX;
            if (r < SAT_MIN) r = SAT_MIN;
            res.value = t_sample'(r);
            res.flag = 1'b0;
            return res;
        endfunction

        function void note_sample(t_sample raw);
            owed.push_back(map_sample(raw));
        endfunction

        function void check_output(t_sample value, logic flag);
            t_cal_out want;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing owed: value %0d flag %b", $time, value, flag);
                fail_count++;
                return;
            end
            want = owed.pop_front();
            if (value !== want.value) begin
                $display("%0t: calibrated_value expected %0d actual %0d",
                         $time, want.value, value);
                fail_count++;
            end
            if (flag !== want.flag) begin
                $display("%0t: setup_invalid expected %b actual %b", $time, want.flag, flag);
                fail_count++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_sample              i_raw_sample;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_sample              i_cfg_data;
    logic                 o_valid;
    t_sample              o_calibrated_value;
    logic                 o_setup_invalid;

    calib_tracker tracker;
    int           beats_taken;
    bit           gaps_on;

    three_point_stick_calibration_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_raw_sample       (i_raw_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_calibrated_value (o_calibrated_value),
        .o_setup_invalid    (o_setup_invalid)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                tracker.note_sample(i_raw_sample);
                beats_taken++;
            end
            if (o_valid)
                tracker.check_output(o_calibrated_value, o_setup_invalid);
        end
    end

    function automatic t_sample clip16(longint v);
        if (v > SAT_MAX) return t_sample'(SAT_MAX);
        if (v < SAT_MIN) return t_sample'(SAT_MIN);
        return t_sample'(v);
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a sample close to one of the three calibration points, or anywhere
    function automatic t_sample pick_sample();
        longint p;
        case ($urandom_range(0, 5))
            0: p = tracker.reg_low;
            1: p = tracker.reg_center;
            2: p = tracker.reg_high;
            default: return t_sample'($urandom());
        endcase
        return clip16(p + longint'($urandom_range(0, 8)) - 4);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_sample(t_sample v);
        int seen;
        seen = beats_taken;
        start <= 1'b1;
        i_raw_sample <= v;
        @(negedge i_clk);
        while (beats_taken == seen) @(negedge i_clk);
    endtask

    task automatic feed(t_sample v);
        int gap;
        send_sample(v);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_sample data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        tracker.set_register(idx, data);
    endtask

    task automatic write_setup(t_sample lo, t_sample ce, t_sample hi);
        write_reg(CFG_CAL_LOW, lo);
        write_reg(CFG_CAL_CENTER, ce);
        // the spare index must leave the setup alone
        if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, t_sample'($urandom()));
        write_reg(CFG_CAL_HIGH, hi);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_setup(int phase);
        longint ce;
        longint lo;
        longint hi;
        if (phase == 0) begin
            write_setup(t_sample'(SAT_MIN), '0, t_sample'(SAT_MAX));
            return;
        end
        if (phase == 1) begin
            write_setup(t_sample'(SAT_MAX), '0, t_sample'(SAT_MIN));
            return;
        end
        ce = t_sample'($urandom());
        case ($urandom_range(0, 5))
            0: begin
                lo = t_sample'($urandom());
                hi = t_sample'($urandom());
            end
            1: begin
                lo = ce;
                hi = t_sample'($urandom());
                if ($urandom_range(0, 1)) begin
                    hi = ce;
                    lo = t_sample'($urandom());
                end
            end
            2: begin
                lo = clip16(ce + $urandom_range(1, 3000));
                if (lo == ce) lo = ce - 1;
                hi = lo;
            end
            3: begin
                lo = ce - $urandom_range(1, 3000);
                hi = ce + $urandom_range(1, 3000);
            end
            4: begin
                lo = ce + $urandom_range(1, 3000);
                hi = ce - $urandom_range(1, 3000);
            end
            default: begin
                lo = ce - $urandom_range(1, 4);
                hi = ce + $urandom_range(1, 4);
                if ($urandom_range(0, 1)) begin
                    lo = ce + $urandom_range(1, 4);
                    hi = ce - $urandom_range(1, 4);
                end
            end
        endcase
        write_setup(clip16(lo), t_sample'(ce), clip16(hi));
    endtask

    initial begin
        #6_000_000;
        $display("three_point_stick_calibration_top verification failed");
        $finish;
    end

    initial begin
        int phase;
        int n;
        tracker = new();
        beats_taken = 0;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_raw_sample = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CAL_LOW;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup reads as degenerate, samples pass through
        feed(t_sample'(SAT_MIN));
        feed(t_sample'(SAT_MAX));
        feed('0);
        feed(-16'sd1);
        feed(16'sd1);
        drain();

        write_setup(-16'sd1000, '0, 16'sd1000);
        feed(t_sample'(SAT_MIN));
        feed(-16'sd1001);
        feed(-16'sd1000);
        feed(-16'sd999);
        feed('0);
        feed(16'sd1);
        feed(16'sd999);
        feed(16'sd1000);
        feed(16'sd1001);
        feed(t_sample'(SAT_MAX));
        drain();

        write_setup(16'sd1000, '0, -16'sd1000);
        feed(-16'sd1000);
        feed('0);
        feed(16'sd1);
        feed(16'sd1000);
        feed(t_sample'(SAT_MAX));
        feed(t_sample'(SAT_MIN));
        drain();

        // low equals high with center elsewhere takes the inverted path
        write_setup(16'sd500, -16'sd500, 16'sd500);
        feed('0);
        feed(-16'sd500);
        feed(16'sd500);
        drain();

        for (phase = 0; phase < RANDOM_SETUPS; phase++) begin
            random_setup(phase);
            gaps_on = (phase % 4) != 3;
            for (n = 0; n < SAMPLES_PER_SETUP; n++)
                feed(pick_sample());
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("three_point_stick_calibration_top verification clean");
        end else begin
            $display("three_point_stick_calibration_top verification failed");
        end
        $finish;
    end

endmodule
